[src/pgf_pkg.sv]
// Shared types, constants and helper functions of the Green function mirror fill block.
package pgf_pkg;

  localparam int MAX_GRID = 256;
  localparam int GW = 9;
  localparam int PW = 11;
  localparam int CW = 32;
  localparam int IW = 25;
  localparam int AW = 28;
  localparam int VW = 32;
  localparam int DW = $clog2(2 * MAX_GRID + 1);
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int QDEPTH = 2;

  localparam logic [GW-1:0] GRID_RESET = GW'(32);
  localparam logic [PW-1:0] ROW_RESET = PW'(66);
  localparam logic [CW-1:0] CELL_RESET = CW'(32'h0100_0000);
  localparam logic [VW-1:0] VAL_MAX = '1;

  typedef enum logic [2:0] {
    REG_GRID_X,
    REG_GRID_Y,
    REG_GRID_Z,
    REG_PADDED_ROW,
    REG_CELL_X,
    REG_CELL_Y,
    REG_CELL_Z
  } reg_e;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_PROD,
    FS_CHECK,
    FS_DIVZ,
    FS_DIVY,
    FS_CLASS,
    FS_SQ,
    FS_PART,
    FS_ACC,
    FS_CHKS,
    FS_DIVG,
    FS_SQRT,
    FS_DIVO,
    FS_PUSH
  } front_state_e;

  typedef struct packed {
    logic [GW-1:0] grid_x;
    logic [GW-1:0] grid_y;
    logic [GW-1:0] grid_z;
    logic [PW-1:0] padded_row;
    logic [CW-1:0] cell_x;
    logic [CW-1:0] cell_y;
    logic [CW-1:0] cell_z;
  } cfg_t;

  typedef struct packed {
    logic [GW-1:0] ix;
    logic [GW-1:0] iy;
    logic [GW-1:0] iz;
    logic [VW-1:0] value;
  } point_t;

  function automatic logic [GW-1:0] clamp_grid(input logic [GW-1:0] g);
    logic [GW-1:0] r;
    r = g;
    if (g == '0) r = GW'(1);
    else if (g > GW'(MAX_GRID)) r = GW'(MAX_GRID);
    return r;
  endfunction

  function automatic logic [DW-1:0] mirror(input logic [DW-1:0] d, input logic [GW-1:0] i);
    logic [DW-1:0] m;
    m = d - DW'(i);
    if (i == '0) m = '0;
    return m;
  endfunction

endpackage

[src/pgf_front.sv]
// Front part: takes an index, splits it into coordinates and computes the Green function value.
module pgf_front import pgf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [IW-1:0] grid_index_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output point_t        push_data_o
);

  localparam int NUMW = 81;
  localparam int DENW = 84;
  localparam int REMW = DENW + 1;
  localparam int CNTW = $clog2(NUMW + 1);
  localparam int GXYW = 2 * GW;
  localparam int GXYZW = 3 * GW;
  localparam int ISQW = 2 * GW;
  localparam int PPW = CW + ISQW;
  localparam int SQW = 64;
  localparam int ORIGW = 44;
  localparam logic [ORIGW-1:0] ORIGIN_NUM = {4'b1110, 40'd0};
  localparam logic [DENW-1:0] S_SMALL = DENW'(65536);

  front_state_e state_q, state_d;

  logic            buf_v_q;
  logic [IW-1:0]   buf_idx_q;
  logic [IW-1:0]   idx_q;
  logic [GXYW-1:0] gxy_q;
  logic [GXYZW-1:0] gxyz_q;
  logic [NUMW-1:0] num_q;
  logic [REMW-1:0] rem_q;
  logic [DENW-1:0] den_q;
  logic [NUMW-1:0] quo_q;
  logic [CNTW-1:0] cnt_q;
  logic [GW-1:0]   ix_q, iy_q, iz_q;
  logic [1:0]      axis_q;
  logic [2*CW-1:0] csq_q;
  logic [ISQW-1:0] isq_q;
  logic [PPW-1:0]  plo_q, phi_q;
  logic [DENW-1:0] s_q;
  logic [SQW-1:0]  sq_x_q, sq_res_q, sq_bit_q;
  logic [VW-1:0]   g_q;

  logic [GW-1:0]   gx_c, gy_c, gz_c, gx, gy, gz;
  logic [REMW-1:0] rem_sh, rem_n;
  logic            div_ge;
  logic [SQW-1:0]  sq_t;
  logic            sq_ge;
  logic [CW-1:0]   min_cell;
  logic [CW+2:0]   five_m;
  logic            origin;
  logic [GW-1:0]   i_sel;
  logic [CW-1:0]   c_sel;
  logic            take;

  assign gx_c = clamp_grid(cfg_i.grid_x);
  assign gy_c = clamp_grid(cfg_i.grid_y);
  assign gz_c = clamp_grid(cfg_i.grid_z);
  assign gx = gx_c + GW'(1);
  assign gy = gy_c + GW'(1);
  assign gz = gz_c + GW'(1);

  assign in_ready_o = !buf_v_q;
  assign take = (state_q == FS_IDLE) && buf_v_q;

  assign rem_sh = {rem_q[REMW-2:0], num_q[NUMW-1]};
  assign div_ge = rem_sh >= {1'b0, den_q};
  assign rem_n = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  assign sq_t = sq_res_q + sq_bit_q;
  assign sq_ge = sq_x_q >= sq_t;

  always_comb begin
    min_cell = cfg_i.cell_x;
    if (cfg_i.cell_y < min_cell) min_cell = cfg_i.cell_y;
    if (cfg_i.cell_z < min_cell) min_cell = cfg_i.cell_z;
  end

  assign five_m = ({3'b000, min_cell} << 2) + {3'b000, min_cell};
  assign origin = (ix_q == '0) && (iy_q == '0) && (iz_q == '0);

  always_comb begin
    case (axis_q)
      2'd0: begin
        i_sel = ix_q;
        c_sel = cfg_i.cell_x;
      end
      2'd1: begin
        i_sel = iy_q;
        c_sel = cfg_i.cell_y;
      end
      default: begin
        i_sel = iz_q;
        c_sel = cfg_i.cell_z;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    push_valid_o = 1'b0;
    unique case (state_q)
      FS_IDLE:  if (buf_v_q) state_d = FS_PROD;
      FS_PROD:  state_d = FS_CHECK;
      FS_CHECK: state_d = ({2'b00, idx_q} >= gxyz_q) ? FS_IDLE : FS_DIVZ;
      FS_DIVZ:  if (cnt_q == '0) state_d = FS_DIVY;
      FS_DIVY:  if (cnt_q == '0) state_d = FS_CLASS;
      FS_CLASS: begin
        if (!origin) state_d = FS_SQ;
        else if (min_cell == '0) state_d = FS_PUSH;
        else state_d = FS_DIVO;
      end
      FS_SQ:    state_d = FS_PART;
      FS_PART:  state_d = FS_ACC;
      FS_ACC:   state_d = (axis_q == 2'd2) ? FS_CHKS : FS_SQ;
      FS_CHKS:  state_d = (s_q <= S_SMALL) ? FS_PUSH : FS_DIVG;
      FS_DIVG:  if (cnt_q == '0) state_d = FS_SQRT;
      FS_SQRT:  if (cnt_q == '0) state_d = FS_PUSH;
      FS_DIVO:  if (cnt_q == '0) state_d = FS_PUSH;
      FS_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) state_d = FS_IDLE;
      end
      default:  state_d = FS_IDLE;
    endcase
  end

  assign push_data_o = '{ix: ix_q, iy: iy_q, iz: iz_q, value: g_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      buf_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) buf_v_q <= 1'b1;
      else if (take) buf_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) buf_idx_q <= grid_index_i;
    case (state_q)
      FS_IDLE: begin
        if (buf_v_q) begin
          idx_q <= buf_idx_q;
          gxy_q <= GXYW'(gx) * GXYW'(gy);
        end
      end
      FS_PROD: gxyz_q <= GXYZW'(gxy_q) * GXYZW'(gz);
      FS_CHECK: begin
        num_q <= {idx_q, (NUMW-IW)'(0)};
        rem_q <= '0;
        quo_q <= '0;
        den_q <= DENW'(gxy_q);
        cnt_q <= CNTW'(IW);
      end
      FS_DIVZ, FS_DIVY, FS_DIVG, FS_DIVO: begin
        if (cnt_q != '0) begin
          rem_q <= rem_n;
          quo_q <= {quo_q[NUMW-2:0], div_ge};
          num_q <= {num_q[NUMW-2:0], 1'b0};
          cnt_q <= cnt_q - CNTW'(1);
        end else if (state_q == FS_DIVZ) begin
          iz_q <= quo_q[GW-1:0];
          num_q <= {rem_q[IW-1:0], (NUMW-IW)'(0)};
          rem_q <= '0;
          quo_q <= '0;
          den_q <= DENW'(gx);
          cnt_q <= CNTW'(IW);
        end else if (state_q == FS_DIVY) begin
          iy_q <= quo_q[GW-1:0];
          ix_q <= rem_q[GW-1:0];
          s_q <= '0;
          axis_q <= '0;
        end else if (state_q == FS_DIVG) begin
          sq_x_q <= quo_q[SQW-1:0];
          sq_res_q <= '0;
          sq_bit_q <= {2'b01, (SQW-2)'(0)};
          cnt_q <= CNTW'(SQW / 2);
        end else begin
          g_q <= (|quo_q[NUMW-1:VW]) ? VAL_MAX : quo_q[VW-1:0];
        end
      end
      FS_CLASS: begin
        g_q <= VAL_MAX;
        num_q <= {ORIGIN_NUM, (NUMW-ORIGW)'(0)};
        rem_q <= '0;
        quo_q <= '0;
        den_q <= DENW'(five_m);
        cnt_q <= CNTW'(ORIGW);
      end
      FS_SQ: begin
        csq_q <= (2*CW)'(c_sel) * (2*CW)'(c_sel);
        isq_q <= ISQW'(i_sel) * ISQW'(i_sel);
      end
      FS_PART: begin
        plo_q <= PPW'(csq_q[CW-1:0]) * PPW'(isq_q);
        phi_q <= PPW'(csq_q[2*CW-1:CW]) * PPW'(isq_q);
      end
      FS_ACC: begin
        s_q <= s_q + DENW'(plo_q) + (DENW'(phi_q) << CW);
        axis_q <= axis_q + 2'd1;
      end
      FS_CHKS: begin
        g_q <= VAL_MAX;
        num_q <= {1'b1, (NUMW-1)'(0)};
        rem_q <= '0;
        quo_q <= '0;
        den_q <= s_q;
        cnt_q <= CNTW'(NUMW);
      end
      FS_SQRT: begin
        if (cnt_q != '0) begin
          if (sq_ge) begin
            sq_x_q <= sq_x_q - sq_t;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          cnt_q <= cnt_q - CNTW'(1);
        end else begin
          g_q <= sq_res_q[VW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> (ix_q <= gx_c && iy_q <= gy_c && iz_q <= gz_c))
    else $error("coordinate outside the point grid");
  a_buffer_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input buffer did not hold the beat");
  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FS_SQRT && cnt_q != '0) |-> $onehot(sq_bit_q))
    else $error("square root step bit lost");
`endif

endmodule

[src/pgf_queue.sv]
// Short queue of finished points between the front and back parts.
module pgf_queue import pgf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  point_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output point_t pop_data_o
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  point_t         mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q;
  logic           push_fire, pop_fire;

  assign push_ready_o = count_q != QCW'(QDEPTH);
  assign pop_valid_o = count_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign push_fire = push_valid_i && push_ready_o;
  assign pop_fire = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_fire) wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
      if (pop_fire) rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
      if (push_fire && !pop_fire) count_q <= count_q + QCW'(1);
      else if (pop_fire && !push_fire) count_q <= count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) mem_q[wr_ptr_q] <= push_data_i;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCW'(QDEPTH))
    else $error("queue count overflow");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_fire && !pop_fire) |=> (count_q == $past(count_q) + QCW'(1)))
    else $error("queue count did not rise on push");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_fire && !push_fire) |=> (count_q == $past(count_q) - QCW'(1)))
    else $error("queue count did not fall on pop");
`endif

endmodule

[src/pgf_back.sv]
// Back part: eight mirrored addresses per point, sent one write beat per cycle unless stalled.
module pgf_back import pgf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  point_t        pop_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [AW-1:0] write_address_o,
  output logic [VW-1:0] write_value_o,
  output logic          last_write_o
);

  localparam int ZW = 2 * DW + 1;
  localparam int RPW = ZW + PW;

  logic [DW-1:0] dgx, dgy, dgz;

  logic          p1_v_q;
  logic [DW-1:0] p1_x_q [2];
  logic [DW-1:0] p1_y_q [2];
  logic [ZW-1:0] p1_za_q, p1_zb_q;
  logic [VW-1:0] p1_g_q;

  logic          p2_v_q;
  logic [AW-1:0] p2_rows_q [4];
  logic [DW-1:0] p2_x_q [2];
  logic [VW-1:0] p2_g_q;

  logic          cur_v_q;
  logic [AW-1:0] cur_rows_q [4];
  logic [DW-1:0] cur_x_q [2];
  logic [VW-1:0] cur_g_q;
  logic [2:0]    k_q;

  logic          out_v_q;
  logic [AW-1:0] addr_q;
  logic [VW-1:0] val_q;
  logic          last_q;

  logic          p1_load, p2_load, cur_load, out_load, cur_done;
  logic [DW-1:0] mz;

  assign dgx = {clamp_grid(cfg_i.grid_x), 1'b0};
  assign dgy = {clamp_grid(cfg_i.grid_y), 1'b0};
  assign dgz = {clamp_grid(cfg_i.grid_z), 1'b0};
  assign mz = mirror(dgz, pop_data_i.iz);

  assign out_load = cur_v_q && (!out_v_q || out_ready_i);
  assign cur_done = out_load && (k_q == 3'd7);
  assign cur_load = p2_v_q && (!cur_v_q || cur_done);
  assign p2_load = p1_v_q && (!p2_v_q || cur_load);
  assign pop_ready_o = !p1_v_q || p2_load;
  assign p1_load = pop_valid_i && pop_ready_o;

  assign out_valid_o = out_v_q;
  assign write_address_o = addr_q;
  assign write_value_o = val_q;
  assign last_write_o = last_q;

  function automatic logic [AW-1:0] row_addr(input logic [ZW-1:0] z, input logic [DW-1:0] y,
                                             input logic [PW-1:0] pr);
    logic [ZW-1:0] s;
    s = z + ZW'(y);
    return AW'(RPW'(s) * RPW'(pr));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      cur_v_q <= 1'b0;
      out_v_q <= 1'b0;
      k_q <= '0;
    end else begin
      if (p1_load) p1_v_q <= 1'b1;
      else if (p2_load) p1_v_q <= 1'b0;
      if (p2_load) p2_v_q <= 1'b1;
      else if (cur_load) p2_v_q <= 1'b0;
      if (cur_load) cur_v_q <= 1'b1;
      else if (cur_done) cur_v_q <= 1'b0;
      if (out_load) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      if (cur_load) k_q <= '0;
      else if (out_load) k_q <= k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_load) begin
      p1_x_q[0] <= DW'(pop_data_i.ix);
      p1_x_q[1] <= mirror(dgx, pop_data_i.ix);
      p1_y_q[0] <= DW'(pop_data_i.iy);
      p1_y_q[1] <= mirror(dgy, pop_data_i.iy);
      p1_za_q <= ZW'(pop_data_i.iz) * ZW'(dgy);
      p1_zb_q <= ZW'(mz) * ZW'(dgy);
      p1_g_q <= pop_data_i.value;
    end
    if (p2_load) begin
      p2_rows_q[0] <= row_addr(p1_za_q, p1_y_q[0], cfg_i.padded_row);
      p2_rows_q[1] <= row_addr(p1_za_q, p1_y_q[1], cfg_i.padded_row);
      p2_rows_q[2] <= row_addr(p1_zb_q, p1_y_q[0], cfg_i.padded_row);
      p2_rows_q[3] <= row_addr(p1_zb_q, p1_y_q[1], cfg_i.padded_row);
      p2_x_q <= p1_x_q;
      p2_g_q <= p1_g_q;
    end
    if (cur_load) begin
      cur_rows_q <= p2_rows_q;
      cur_x_q <= p2_x_q;
      cur_g_q <= p2_g_q;
    end
    if (out_load) begin
      addr_q <= cur_rows_q[{k_q[2], k_q[0]}] + AW'(cur_x_q[k_q[1]]);
      val_q <= cur_g_q;
      last_q <= k_q == 3'd7;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && k_q == 3'd7) |=> last_write_o)
    else $error("eighth beat not marked last");
  a_mid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && k_q != 3'd7) |=> (!last_write_o && cur_v_q))
    else $error("beat marked last too early");
  a_cur_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_load |=> (cur_v_q && k_q == 3'd0))
    else $error("new point did not start at its first beat");
`endif

endmodule

[src/point_green_function_mirror_fill.sv]
// Top level of the Green function mirror fill block with its configuration registers.
// An index outside the point grid is dropped; the origin skips the square-root steps.
// The front works one index at a time on its shared iterative divider and square-root
// unit, holding one more index in its input buffer; the back part sends the eight write
// beats of a point at one beat per cycle while out_ready_i does not stall the output.
// Reset: control state clears and the registers take their reset values; no clearing pass.
module point_green_function_mirror_fill import pgf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [IW-1:0]     grid_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [AW-1:0]     write_address_o,
  output logic [VW-1:0]     write_value_o,
  output logic              last_write_o
);

  cfg_t   cfg_q;
  reg_e   reg_sel;
  logic   wr_en;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  point_t push_data, pop_data;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_x <= GRID_RESET;
      cfg_q.grid_y <= GRID_RESET;
      cfg_q.grid_z <= GRID_RESET;
      cfg_q.padded_row <= ROW_RESET;
      cfg_q.cell_x <= CELL_RESET;
      cfg_q.cell_y <= CELL_RESET;
      cfg_q.cell_z <= CELL_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_GRID_X:     cfg_q.grid_x <= pwdata[GW-1:0];
        REG_GRID_Y:     cfg_q.grid_y <= pwdata[GW-1:0];
        REG_GRID_Z:     cfg_q.grid_z <= pwdata[GW-1:0];
        REG_PADDED_ROW: cfg_q.padded_row <= pwdata[PW-1:0];
        REG_CELL_X:     cfg_q.cell_x <= pwdata[CW-1:0];
        REG_CELL_Y:     cfg_q.cell_y <= pwdata[CW-1:0];
        REG_CELL_Z:     cfg_q.cell_z <= pwdata[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GRID_X:     prdata = APB_DW'(cfg_q.grid_x);
      REG_GRID_Y:     prdata = APB_DW'(cfg_q.grid_y);
      REG_GRID_Z:     prdata = APB_DW'(cfg_q.grid_z);
      REG_PADDED_ROW: prdata = APB_DW'(cfg_q.padded_row);
      REG_CELL_X:     prdata = APB_DW'(cfg_q.cell_x);
      REG_CELL_Y:     prdata = APB_DW'(cfg_q.cell_y);
      REG_CELL_Z:     prdata = APB_DW'(cfg_q.cell_z);
      default:        prdata = '0;
    endcase
  end

  pgf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .grid_index_i (grid_index_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pgf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pgf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_address_o (write_address_o),
    .write_value_o   (write_value_o),
    .last_write_o    (last_write_o)
  );

endmodule
